[rtl/core/binary_to_decimal_ascii_macros.svh]
// Assertion macros used by the checker file.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/b2da_pkg.sv]
package b2da_pkg;

   // input and result widths
   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 6;
   localparam int RSP_W    = 8;
   // one BCD digit per cell; ten digits cover 2^32 - 1
   localparam int DIGIT_W  = 4;
   localparam int DIGITS   = 10;
   localparam int BITCNT_W = $clog2(VALUE_W);
   localparam int REM_W    = $clog2(DIGITS + 1);

   // double-dabble adjust: digits of 5 and up get 3 added before the shift
   localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;

   // control handed to every cell of the chain
   typedef struct packed {
      logic clear;   // zero the digit
      logic conv;    // adjust and shift one binary bit in
      logic shift;   // take the lower neighbor's digit
   } b2da_cell_ctl_type;

endpackage

[rtl/core/b2da_cell.sv]
// One BCD digit of the conversion chain.
module b2da_cell
   import b2da_pkg::*;
(
   input  logic                 clock,
   input  b2da_cell_ctl_type    ctl,
   input  logic                 nbr_bit,     // bit from the lower cell
   input  logic [DIGIT_W-1:0]   nbr_digit,   // digit of the lower cell
   output logic                 bit_out,     // bit toward the upper cell
   output logic [DIGIT_W-1:0]   digit
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   // add 3 when the digit would overflow past 9 after doubling
   assign adj     = (digit_ff >= BCD_ADJ_MIN) ? digit_ff + BCD_ADJ : digit_ff;
   assign bit_out = adj[DIGIT_W-1];
   assign digit   = digit_ff;

   // next digit
   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.conv) begin
         digit_in = {adj[DIGIT_W-2:0], nbr_bit};
      end else if (ctl.shift) begin
         digit_in = nbr_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

[rtl/core/binary_to_decimal_ascii.sv]
// Converts one 32-bit unsigned word on req into its decimal digits as ASCII
// characters on rsp, most significant first, one word per digit, with
// rsp_tlast on the least significant digit. Leading zeros are dropped; zero
// gives a single '0'. A row of ten BCD cells runs shift-and-add-3 over all
// 32 input bits, then skips leading zero digits and shifts the digits out of
// the top cell, one per cycle while rsp is not stalled. Each value passes a
// load, the conversion, the skip of leading zeros and the emission of its
// digits before the next value is accepted. The last digit may still wait in
// the output register while the next value is taken.
module binary_to_decimal_ascii
   import b2da_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [VALUE_W-1:0]   req_tdata,   // [31:0] value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic                 rsp_tlast    // last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [VALUE_W-1:0]  bin_ff, bin_in;
   logic [BITCNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   b2da_cell_ctl_type   ctl;
   logic [DIGIT_W-1:0]  digit [DIGITS];
   logic                carry [DIGITS];
   logic [DIGIT_W-1:0]  top;
   logic                req_fire;
   logic                rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign top        = digit[DIGITS-1];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-CHAR_W){1'b0}}, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bitcnt_in    = bitcnt_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ctl.clear = 1'b1;
               bin_in    = req_tdata;
               bitcnt_in = '0;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            ctl.conv  = 1'b1;
            bin_in    = {bin_ff[VALUE_W-2:0], 1'b0};
            bitcnt_in = bitcnt_ff + 1'b1;
            if (bitcnt_ff == BITCNT_W'(VALUE_W - 1)) begin
               rem_in   = REM_W'(DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top == '0 && rem_ff != REM_W'(1)) begin
               ctl.shift = 1'b1;
               rem_in    = rem_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               ctl.shift    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + CHAR_W'(top);
               rsp_last_in  = (rem_ff == REM_W'(1));
               rem_in       = rem_ff - 1'b1;
               if (rem_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bitcnt_ff    <= '0;
         rem_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bitcnt_ff    <= bitcnt_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // BCD cell chain, least significant digit in cell 0
   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         b2da_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .nbr_bit   (bin_ff[VALUE_W-1]),
            .nbr_digit ({DIGIT_W{1'b0}}),
            .bit_out   (carry[i]),
            .digit     (digit[i])
         );
      end else if (i == DIGITS - 1) begin : g_top
         // the top carry is always zero for 32-bit input
         b2da_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .nbr_bit   (carry[i-1]),
            .nbr_digit (digit[i-1]),
            .bit_out   (carry[i]),
            .digit     (digit[i])
         );
      end else begin : g_mid
         b2da_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .nbr_bit   (carry[i-1]),
            .nbr_digit (digit[i-1]),
            .bit_out   (carry[i]),
            .digit     (digit[i])
         );
      end
   end

endmodule

[rtl/core/b2da_checker.sv]
`include "binary_to_decimal_ascii_macros.svh"

// Port-level checks of the converter.
module b2da_checker
   import b2da_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_W-1:0]     rsp_tdata,
   input logic                 rsp_tlast
);

   // a stalled result word holds
   `B2DA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")

   // every result is an ASCII digit
   `B2DA_ASSERT_NOW(a_rsp_digit, rsp_tvalid, rsp_tdata[7:6] == 2'b00 && rsp_tdata[5:0] >= 6'd48 && rsp_tdata[5:0] <= 6'd57, "rsp word is not a digit")

   // a taken value keeps the block busy for its conversion
   `B2DA_ASSERT_NEXT(a_req_busy, req_tvalid && req_tready, !req_tready, "req taken again right after a word")

   // nothing is offered straight out of reset
   `B2DA_ASSERT_NOW(a_rsp_reset, $past(reset), !rsp_tvalid, "rsp valid right after reset")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/sv/tb_binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;
   import b2da_pkg::*;

   localparam int CLOCK_HALF       = 5;
   localparam int RESET_CYCLES     = 2;
   localparam int WORDS_PER_PHASE  = 62;
   localparam int SETTLE_CYCLES    = 100;     // past one full conversion
   localparam int CYCLE_LIMIT      = 500000;
   localparam int MAX_REPORTS      = 40;
   localparam int NUM_DIRECTED     = 21;

   // one expected character word on rsp
   typedef struct packed {
      logic [CHAR_W-1:0] ascii_code;
      logic              last;
   } digit_word_type;

   // directed row: empty text means the predictor supplies the digits
   typedef struct {
      logic [VALUE_W-1:0] value;
      string              text;
   } directed_row_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata  = '0;   // [31:0] value
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;         // [5:0] digit_char, [7:6] zero
   logic               rsp_tlast;

   digit_word_type expected_digits[$];
   int          error_count    = 0;
   int          cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;

   directed_row_type directed_rows[NUM_DIRECTED] = '{
      '{32'd0,          "0"},
      '{32'd4294967295, "4294967295"},
      '{32'd1,          "1"},
      '{32'd9,          ""},
      '{32'd10,         ""},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'd1000,       ""},
      '{32'd10000000,   ""},
      '{32'd123456789,  ""},
      '{32'd999999999,  ""},
      '{32'd1000000000, ""},
      '{32'd2147483647, ""},
      '{32'd2147483648, ""},
      '{32'd4000000000, ""},
      '{32'd4294967294, ""},
      '{32'd3,          ""},
      '{32'hAAAAAAAA,   ""},
      '{32'h55555555,   ""},
      '{32'h0000FFFF,   ""},
      '{32'h80000001,   ""}
   };

   binary_to_decimal_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // decimal digits of a value, most significant first, last flag on the final one
   function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
      logic [DIGIT_W-1:0] rev_digits[DIGITS];
      logic [VALUE_W-1:0] rest;
      int                 count;
      digit_word_type     word;
      rest  = value;
      count = 0;
      do begin
         rev_digits[count] = DIGIT_W'(rest % 10);
         rest = rest / 10;
         count++;
      end while (rest != 0 && count < DIGITS);
      for (int k = 0; k < count; k++) begin
         word.ascii_code = CHAR_W'(rev_digits[count-1-k]) + ASCII_ZERO;
         word.last       = (k == count - 1);
         expected_digits.push_back(word);
      end
   endfunction

   // digits typed in as text
   function automatic void queue_typed_digits(input string text);
      digit_word_type word;
      for (int i = 0; i < text.len(); i++) begin
         word.ascii_code = CHAR_W'(text[i]);
         word.last       = (i == text.len() - 1);
         expected_digits.push_back(word);
      end
   endfunction

   // mostly an even spread over digit counts, plus raw words and powers of ten
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [63:0] low_bound;
      logic [63:0] high_bound;
      int          ndigits;
      case ($urandom_range(9))
         0: return $urandom;
         1: begin
            low_bound = 1;
            repeat ($urandom_range(9)) low_bound = low_bound * 10;
            return VALUE_W'(low_bound);
         end
         default: begin
            ndigits   = $urandom_range(DIGITS, 1);
            low_bound = 1;
            repeat (ndigits - 1) low_bound = low_bound * 10;
            high_bound = (ndigits == DIGITS) ? 64'hFFFF_FFFF : low_bound * 10 - 1;
            return $urandom_range(VALUE_W'(high_bound), VALUE_W'(low_bound));
         end
      endcase
   endfunction

   // present one word, wait for acceptance, then record what it should produce
   task automatic send_value(input logic [VALUE_W-1:0] value, input string text);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      if (text.len() != 0)
         queue_typed_digits(text);
      else
         queue_decimal_digits(value);
   endtask

   // hold off the sender until every outstanding digit has come back
   task automatic drain_digits();
      req_tvalid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
   endtask

   task automatic check_digit();
      digit_word_type want;
      if (expected_digits.size() == 0) begin
         report_mismatch($sformatf("unexpected word tdata=%0h tlast=%0b", rsp_tdata, rsp_tlast));
      end else begin
         want = expected_digits.pop_front();
         if (rsp_tdata[CHAR_W-1:0] !== want.ascii_code)
            report_mismatch($sformatf("digit_char %0d, want %0d",
                                      rsp_tdata[CHAR_W-1:0], want.ascii_code));
         if (rsp_tdata[RSP_W-1:CHAR_W] !== '0)
            report_mismatch($sformatf("pad bits %0b, want zero", rsp_tdata[RSP_W-1:CHAR_W]));
         if (rsp_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", rsp_tlast, want.last));
      end
   endtask

   // result side: check accepted words, then pick next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_digit();
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // stimulus
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, no idling
      foreach (directed_rows[i])
         send_value(directed_rows[i].value, directed_rows[i].text);
      drain_digits();

      // random phases: free run, slow sender, slow receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         repeat (WORDS_PER_PHASE) send_value(pick_value(), "");
         drain_digits();
      end

      // catch any stray words after the last digit
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/b2da_pkg.sv
rtl/core/b2da_cell.sv
rtl/core/binary_to_decimal_ascii.sv
rtl/core/b2da_checker.sv
tb/sv/tb_binary_to_decimal_ascii.sv
